/* sv/cps_pkg.sv */
// ---------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the channel pedestal statistics core.
// ---------------------------------------------------------------------------
package cps_pkg;

  localparam int CH_W   = 9;
  localparam int ADC_W  = 16;
  localparam int CNT_W  = 24;
  localparam int SUM_W  = 40;
  localparam int SQ_W   = 56;
  localparam int Q8_W   = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_CW = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  localparam logic [IDX_CW-1:0] REG_ADC_LIMIT   = 3'd0;
  localparam logic [IDX_CW-1:0] REG_PMT_COUNT   = 3'd1;
  localparam logic [IDX_CW-1:0] REG_OFF_UPPER   = 3'd2;
  localparam logic [IDX_CW-1:0] REG_OFF_LOWER   = 3'd3;
  localparam logic [IDX_CW-1:0] REG_PED_LOW     = 3'd4;
  localparam logic [IDX_CW-1:0] REG_PED_HIGH    = 3'd5;
  localparam logic [IDX_CW-1:0] REG_SPREAD_LOW  = 3'd6;
  localparam logic [IDX_CW-1:0] REG_SPREAD_HIGH = 3'd7;

  typedef struct packed {
    logic             func;
    logic             chan_ok;
    logic [CH_W-1:0]  channel;
    logic             take;
    logic [ADC_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sqsum;
  } entry_t;

  typedef struct packed {
    logic [Q8_W-1:0] mean;
    logic [Q8_W-1:0] spread;
  } stats_t;

  typedef struct packed {
    logic [9:0]      pmt_count;
    logic [Q8_W-1:0] off_upper;
    logic [Q8_W-1:0] off_lower;
    logic [Q8_W-1:0] ped_low;
    logic [Q8_W-1:0] ped_high;
    logic [Q8_W-1:0] spread_low;
    logic [Q8_W-1:0] spread_high;
  } cfg_t;

endpackage

/* sv/cps_front.sv */
// ---------------------------------------------------------------------------
// cps_front
// Classifies an incoming transaction: magnitude and accumulate decision.
// ---------------------------------------------------------------------------
module cps_front #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic                       func,
  input  logic [cps_pkg::CH_W-1:0]   channel,
  input  logic [cps_pkg::ADC_W-1:0]  adc_value,
  input  logic [15:0]                event_code,
  input  logic [cps_pkg::CFG_W-1:0]  adc_limit,
  output cps_pkg::item_t             item
);

  logic [cps_pkg::ADC_W-1:0] mag;
  logic                      chan_ok;

  // two's complement magnitude, -32768 gives 32768
  assign mag     = adc_value[15] ? cps_pkg::ADC_W'(17'h10000 - {1'b0, adc_value}) : adc_value;
  assign chan_ok = (32'(channel) < NUM_CHANNELS);

  always_comb begin
    item.func    = func;
    item.chan_ok = chan_ok;
    item.channel = channel;
    item.mag     = mag;
    item.take    = event_code[0] && (mag != '0) && (mag < adc_limit) && chan_ok;
  end

endmodule

/* sv/cps_queue.sv */
// ---------------------------------------------------------------------------
// cps_queue
// Small register queue between front and back.
// ---------------------------------------------------------------------------
module cps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cps_pkg::item_t push_item,
  input  logic           pop,
  output cps_pkg::item_t head,
  output logic           not_empty,
  output logic           full
);

  cps_pkg::item_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign head      = slots[rd_ptr];
  assign not_empty = (fill != 3'd0);
  assign full      = (fill == 3'd4);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("queue pop while empty");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + 3'd1)
    else $error("queue fill count slipped");

endmodule

/* sv/cps_stats.sv */
// ---------------------------------------------------------------------------
// cps_stats
// Iterative mean and standard deviation unit: serial multiply, restoring
// divide and bitwise square root, run in sequence by one state machine.
// ---------------------------------------------------------------------------
module cps_stats (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [cps_pkg::CNT_W-1:0]   n_in,
  input  logic [cps_pkg::SUM_W-1:0]   s_in,
  input  logic [cps_pkg::SQ_W-1:0]    sq_in,
  output logic                        ready,
  output cps_pkg::stats_t             result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MULSQ  = 3'd1;
  localparam logic [2:0] ST_SUBSS  = 3'd2;
  localparam logic [2:0] ST_MULD   = 3'd3;
  localparam logic [2:0] ST_DIVM   = 3'd4;
  localparam logic [2:0] ST_DIVS   = 3'd5;
  localparam logic [2:0] ST_SQRT   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]  state;
  logic [6:0]  cnt;
  logic [23:0] n;
  logic [39:0] s;
  logic [79:0] acc;
  logic [79:0] mcand;
  logic [39:0] mplier;
  logic [47:0] d;
  logic [95:0] dvd;
  logic [48:0] rem;
  logic [47:0] q;
  logic        ovf;
  logic [31:0] x;
  logic [31:0] res;
  logic [31:0] bitv;

  logic [47:0] divisor;
  logic [48:0] rem_sh;
  logic        ge;
  logic [48:0] rem_new;
  logic [47:0] q_new;
  logic [31:0] trial;
  logic        sq_ge;
  logic [31:0] res_new;

  assign ready = (state == ST_DONE);

  always_comb begin
    divisor = (state == ST_DIVM) ? 48'(n) : d;
    rem_sh  = {rem[47:0], dvd[95]};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_new = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
    q_new   = {q[46:0], ge};
    trial   = res + bitv;
    sq_ge   = (x >= trial);
    res_new = sq_ge ? ((res >> 1) + bitv) : (res >> 1);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_MULSQ: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        if (cnt == 7'd23) begin
          mcand  <= 80'(s);
          mplier <= s;
        end
      end
      ST_SUBSS: begin
        // partial sums of s*s never exceed n*sumsq, so acc stays nonnegative
        if (mplier[0]) acc <= acc - mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        if (cnt == 7'd39) begin
          mcand  <= 80'(n);
          mplier <= 40'(n - 24'd1);
          d      <= '0;
        end
      end
      ST_MULD: begin
        if (mplier[0]) d <= d + mcand[47:0];
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        if (cnt == 7'd23) begin
          dvd <= {s, 8'b0, 48'b0};
          rem <= '0;
          q   <= '0;
        end
      end
      ST_DIVM: begin
        rem <= rem_new;
        q   <= q_new;
        dvd <= dvd << 1;
        if (cnt == 7'd47) begin
          result.mean <= (q_new > 48'(16'hFFFF)) ? 16'hFFFF : q_new[15:0];
          dvd <= {acc, 16'b0};
          rem <= '0;
          q   <= '0;
          ovf <= 1'b0;
        end
      end
      ST_DIVS: begin
        rem <= rem_new;
        q   <= q_new;
        dvd <= dvd << 1;
        ovf <= ovf | q[31];
        if (cnt == 7'd95) begin
          // quotient above 32 bits saturates to all ones, whose root is 65535
          x    <= (ovf | q[31]) ? 32'hFFFFFFFF : q_new[31:0];
          res  <= '0;
          bitv <= 32'h40000000;
        end
      end
      ST_SQRT: begin
        if (sq_ge) x <= x - trial;
        res  <= res_new;
        bitv <= bitv >> 2;
        if (cnt == 7'd15) result.spread <= res_new[15:0];
      end
      default: begin
        if (go) begin
          n      <= n_in;
          s      <= s_in;
          acc    <= '0;
          mcand  <= 80'(sq_in);
          mplier <= 40'(n_in);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      cnt <= cnt + 7'd1;
      case (state)
        ST_IDLE:  begin cnt <= '0; if (go) state <= ST_MULSQ; end
        ST_MULSQ: if (cnt == 7'd23) begin state <= ST_SUBSS; cnt <= '0; end
        ST_SUBSS: if (cnt == 7'd39) begin state <= ST_MULD;  cnt <= '0; end
        ST_MULD:  if (cnt == 7'd23) begin state <= ST_DIVM;  cnt <= '0; end
        ST_DIVM:  if (cnt == 7'd47) begin state <= ST_DIVS;  cnt <= '0; end
        ST_DIVS:  if (cnt == 7'd95) begin state <= ST_SQRT;  cnt <= '0; end
        ST_SQRT:  if (cnt == 7'd15) begin state <= ST_DONE;  cnt <= '0; end
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sv/cps_back.sv */
// ---------------------------------------------------------------------------
// cps_back
// Per-channel store, read-modify-write of samples and report sequencing.
// ---------------------------------------------------------------------------
module cps_back #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cps_pkg::item_t               head,
  input  logic                         not_empty,
  output logic                         pop,
  output logic                         clearing,
  input  cps_pkg::cfg_t                cfg,
  output logic                         done,
  output logic [cps_pkg::CH_W-1:0]     report_channel,
  output logic [cps_pkg::Q8_W-1:0]     mean_q8,
  output logic [cps_pkg::Q8_W-1:0]     spread_q8,
  output logic [cps_pkg::CNT_W-1:0]    sample_count,
  output logic                         insufficient,
  output logic                         ped_out_of_range,
  output logic                         spread_out_of_range,
  output logic                         tube_off
);

  localparam int IDX_W = $clog2(NUM_CHANNELS);

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_READ  = 3'd2;
  localparam logic [2:0] B_STATS = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  cps_pkg::entry_t mem [NUM_CHANNELS];
  cps_pkg::entry_t rd_data;
  cps_pkg::entry_t cur;
  cps_pkg::entry_t upd;
  cps_pkg::item_t  item;
  cps_pkg::stats_t st_res;
  cps_pkg::stats_t st;

  logic [2:0]       state;
  logic [IDX_W-1:0] clr_addr;
  logic             we;
  logic [IDX_W-1:0] wr_idx;
  cps_pkg::entry_t  wr_data;
  logic [cps_pkg::CNT_W-1:0] n;
  logic             enough;
  logic             st_go;
  logic             st_ready;
  logic             gate;

  assign clearing = (state == B_CLEAR);
  assign pop      = (state == B_IDLE) && not_empty;

  always_ff @(posedge clk) begin
    rd_data <= mem[IDX_W'(head.channel)];
    if (we) mem[wr_idx] <= wr_data;
  end

  always_comb begin
    cur = item.chan_ok ? rd_data : '0;
    upd.count = cur.count + 24'd1;
    upd.sum   = cur.sum + 40'(item.mag);
    upd.sqsum = cur.sqsum + 56'(32'(item.mag) * 32'(item.mag));
    we      = 1'b0;
    wr_idx  = IDX_W'(item.channel);
    wr_data = upd;
    if (state == B_CLEAR) begin
      we      = 1'b1;
      wr_idx  = clr_addr;
      wr_data = '0;
    end else if (state == B_READ && item.func == cps_pkg::FUNC_SAMPLE &&
                 item.take && cur.count != cps_pkg::COUNT_MAX) begin
      we = 1'b1;
    end
    st_go = (state == B_READ) && (item.func == cps_pkg::FUNC_REPORT) &&
            (cur.count >= 24'd2);
  end

  cps_stats u_stats (
    .clk    (clk),
    .rst    (rst),
    .go     (st_go),
    .n_in   (cur.count),
    .s_in   (cur.sum),
    .sq_in  (cur.sqsum),
    .ready  (st_ready),
    .result (st_res)
  );

  always_ff @(posedge clk) begin
    if (pop) item <= head;
    if (state == B_READ) begin
      n  <= cur.count;
      st <= '0;
    end
    if (state == B_STATS && st_ready) st <= st_res;
  end

  assign enough = (n >= 24'd2);
  assign gate   = ({1'b0, item.channel} < cfg.pmt_count);

  always_ff @(posedge clk) begin
    if (state == B_OUT) begin
      report_channel      <= item.channel;
      mean_q8             <= st.mean;
      spread_q8           <= st.spread;
      sample_count        <= n;
      insufficient        <= gate && !enough;
      ped_out_of_range    <= gate && enough &&
                             (st.mean < cfg.ped_low || st.mean > cfg.ped_high);
      spread_out_of_range <= gate && enough &&
                             (st.spread < cfg.spread_low || st.spread > cfg.spread_high);
      tube_off            <= gate &&
                             (st.spread >= cfg.off_upper || st.spread <= cfg.off_lower);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= (state == B_OUT);
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(NUM_CHANNELS - 1)) state <= B_IDLE;
        end
        B_IDLE: if (not_empty) state <= B_READ;
        B_READ: begin
          if (item.func == cps_pkg::FUNC_SAMPLE) state <= B_IDLE;
          else if (st_go) state <= B_STATS;
          else state <= B_OUT;
        end
        B_STATS: if (st_ready) state <= B_OUT;
        B_OUT:   state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst) clearing |-> !pop)
    else $error("item taken during clearing pass");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("report strobe held");
  a_sample_short: assert property (@(posedge clk) disable iff (rst)
    (state == B_READ && item.func == cps_pkg::FUNC_SAMPLE) |=> state == B_IDLE)
    else $error("sample update did not finish in one cycle");

endmodule

/* sv/channel_pedestal_statistics_core.sv */
// ---------------------------------------------------------------------------
// channel_pedestal_statistics_core
// Per-channel pedestal mean and spread accumulator with quality flags.
// ---------------------------------------------------------------------------
// After reset the store is cleared one channel a cycle while busy stays high.
// A transaction is taken when start is high and busy is low; a four-entry
// queue sits in front of the store sequencer, and busy also rises when that
// queue is full. The sequencer handles a sample as a store read, then a write
// back. A report with two or more samples passes through the serial multiply,
// divide and square root unit before it is output; with fewer samples it is
// output straight after the store read. Each report appears for one cycle with done
// high and cannot be held off by the receiver.
module channel_pedestal_statistics_core #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [cps_pkg::CH_W-1:0]      channel,
  input  logic [cps_pkg::ADC_W-1:0]     adc_value,
  input  logic [15:0]                   event_code,
  input  logic                          cfg_we,
  input  logic [cps_pkg::IDX_CW-1:0]    cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic [cps_pkg::CH_W-1:0]      report_channel,
  output logic [cps_pkg::Q8_W-1:0]      mean_q8,
  output logic [cps_pkg::Q8_W-1:0]      spread_q8,
  output logic [cps_pkg::CNT_W-1:0]     sample_count,
  output logic                          insufficient,
  output logic                          ped_out_of_range,
  output logic                          spread_out_of_range,
  output logic                          tube_off
);

  logic [cps_pkg::CFG_W-1:0] adc_limit;
  cps_pkg::cfg_t  cfg;
  cps_pkg::item_t in_item;
  cps_pkg::item_t head;
  logic           not_empty;
  logic           full;
  logic           pop;
  logic           clearing;
  logic           push;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_limit       <= 16'd100;
      cfg.pmt_count   <= 10'd490;
      cfg.off_upper   <= 16'd1792;
      cfg.off_lower   <= 16'd512;
      cfg.ped_low     <= 16'd2560;
      cfg.ped_high    <= 16'd12800;
      cfg.spread_low  <= 16'd512;
      cfg.spread_high <= 16'd1792;
    end else if (cfg_we) begin
      case (cfg_index)
        cps_pkg::REG_ADC_LIMIT:   adc_limit       <= cfg_data;
        cps_pkg::REG_PMT_COUNT:   cfg.pmt_count   <= cfg_data[9:0];
        cps_pkg::REG_OFF_UPPER:   cfg.off_upper   <= cfg_data;
        cps_pkg::REG_OFF_LOWER:   cfg.off_lower   <= cfg_data;
        cps_pkg::REG_PED_LOW:     cfg.ped_low     <= cfg_data;
        cps_pkg::REG_PED_HIGH:    cfg.ped_high    <= cfg_data;
        cps_pkg::REG_SPREAD_LOW:  cfg.spread_low  <= cfg_data;
        cps_pkg::REG_SPREAD_HIGH: cfg.spread_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = clearing || full;
  assign push = start && !busy;

  cps_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .func       (func),
    .channel    (channel),
    .adc_value  (adc_value),
    .event_code (event_code),
    .adc_limit  (adc_limit),
    .item       (in_item)
  );

  cps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  cps_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head                (head),
    .not_empty           (not_empty),
    .pop                 (pop),
    .clearing            (clearing),
    .cfg                 (cfg),
    .done                (done),
    .report_channel      (report_channel),
    .mean_q8             (mean_q8),
    .spread_q8           (spread_q8),
    .sample_count        (sample_count),
    .insufficient        (insufficient),
    .ped_out_of_range    (ped_out_of_range),
    .spread_out_of_range (spread_out_of_range),
    .tube_off            (tube_off)
  );

endmodule

/* verif/tb_channel_pedestal_statistics_core.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_channel_pedestal_statistics_core
// Self-checking bench for the per-channel pedestal statistics core: a short
// table of directed transactions, then random bursts of samples and reports
// under several register settings; each report is checked against its table
// entry or a local statistics predictor.
// ---------------------------------------------------------------------------
module tb_channel_pedestal_statistics_core;

  localparam int NCH        = 512;
  localparam int CYCLE_MAX  = 3000000;
  localparam int ITEMS_EACH = 400;
  localparam int NPHASE     = 5;
  localparam int SETTLE     = 40;
  localparam int TAIL       = 400;

  typedef struct packed {
    logic [cps_pkg::CH_W-1:0]  ch;
    logic [cps_pkg::Q8_W-1:0]  mean;
    logic [cps_pkg::Q8_W-1:0]  spread;
    logic [cps_pkg::CNT_W-1:0] cnt;
    logic                      insuff;
    logic                      ped_oor;
    logic                      spr_oor;
    logic                      off;
  } report_t;

  typedef struct {
    logic                      f;
    logic [cps_pkg::CH_W-1:0]  ch;
    logic [cps_pkg::ADC_W-1:0] adc;
    logic [15:0]               code;
    bit                        typed;
    report_t                   exp;
  } row_t;

  logic clk, rst, start, busy, func, cfg_we, done;
  logic [cps_pkg::CH_W-1:0]   channel, report_channel;
  logic [cps_pkg::ADC_W-1:0]  adc_value;
  logic [15:0]                event_code;
  logic [cps_pkg::IDX_CW-1:0] cfg_index;
  logic [cps_pkg::CFG_W-1:0]  cfg_data;
  logic [cps_pkg::Q8_W-1:0]   mean_q8, spread_q8;
  logic [cps_pkg::CNT_W-1:0]  sample_count;
  logic insufficient, ped_out_of_range, spread_out_of_range, tube_off;

  channel_pedestal_statistics_core #(.NUM_CHANNELS(NCH)) u_top (.*);

  // predictor state
  logic [cps_pkg::SUM_W-1:0] ch_sum   [NCH];
  logic [cps_pkg::SQ_W-1:0]  ch_sqsum [NCH];
  logic [cps_pkg::CNT_W-1:0] ch_cnt   [NCH];
  logic [15:0] lim_adc, lim_off_up, lim_off_lo, lim_ped_lo, lim_ped_hi;
  logic [15:0] lim_spr_lo, lim_spr_hi;
  logic [9:0]  lim_pmt;

  report_t pending_reports[$];
  int errors = 0, reports_seen = 0, samples_sent = 0, cycles = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic report_t channel_stats(input logic [cps_pkg::CH_W-1:0] ch);
    report_t r;
    logic [63:0]  n, s, m;
    logic [127:0] num, q;
    bit gate, enough;
    n = 64'(ch_cnt[ch]);
    s = 64'(ch_sum[ch]);
    r = '0;
    r.ch = ch;
    r.cnt = ch_cnt[ch];
    gate = ({1'b0, ch} < lim_pmt);
    enough = n >= 64'd2;
    if (enough) begin
      m = (s << 8) / n;
      r.mean = (m > 64'd65535) ? 16'hFFFF : m[15:0];
      num = (128'(n) * 128'(ch_sqsum[ch]) - 128'(s) * 128'(s)) << 16;
      q = num / 128'(n * (n - 64'd1));
      if (q > 128'hFFFF_FFFF) r.spread = 16'hFFFF;
      else begin
        m = 64'(int_sqrt(q[63:0]));
        r.spread = (m > 64'd65535) ? 16'hFFFF : m[15:0];
      end
    end
    r.insuff  = gate && !enough;
    r.ped_oor = gate && enough && (r.mean < lim_ped_lo || r.mean > lim_ped_hi);
    r.spr_oor = gate && enough && (r.spread < lim_spr_lo || r.spread > lim_spr_hi);
    r.off     = gate && (r.spread >= lim_off_up || r.spread <= lim_off_lo);
    return r;
  endfunction

  function automatic void accumulate(input logic [cps_pkg::CH_W-1:0] ch,
                                     input logic [15:0] adc, input logic [15:0] code);
    logic [16:0] mag;
    mag = adc[15] ? (17'h10000 - {1'b0, adc}) : {1'b0, adc};
    if (code[0] && mag != 17'd0 && mag < {1'b0, lim_adc} &&
        ch_cnt[ch] < cps_pkg::COUNT_MAX) begin
      ch_sum[ch]   += 40'(mag);
      ch_sqsum[ch] += 56'(mag) * 56'(mag);
      ch_cnt[ch]   += 24'd1;
    end
  endfunction

  // one transaction, with burst-and-gap pacing of the sender
  task automatic send_item(input logic f, input logic [cps_pkg::CH_W-1:0] ch,
                           input logic [15:0] adc, input logic [15:0] code,
                           input bit typed, input report_t exp);
    start <= 1'b1;
    func <= f;
    channel <= ch;
    adc_value <= adc;
    event_code <= code;
    do @(posedge clk); while (busy);
    if (f == cps_pkg::FUNC_REPORT) pending_reports.push_back(typed ? exp : channel_stats(ch));
    else begin
      accumulate(ch, adc, code);
      samples_sent++;
    end
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(40, 80))
                                               : int'($urandom_range(1, 15));
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cps_pkg::IDX_CW-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      cps_pkg::REG_ADC_LIMIT:   lim_adc = val;
      cps_pkg::REG_PMT_COUNT:   lim_pmt = val[9:0];
      cps_pkg::REG_OFF_UPPER:   lim_off_up = val;
      cps_pkg::REG_OFF_LOWER:   lim_off_lo = val;
      cps_pkg::REG_PED_LOW:     lim_ped_lo = val;
      cps_pkg::REG_PED_HIGH:    lim_ped_hi = val;
      cps_pkg::REG_SPREAD_LOW:  lim_spr_lo = val;
      cps_pkg::REG_SPREAD_HIGH: lim_spr_hi = val;
      default: ;
    endcase
  endtask

  // report checker: the receiver has no back-pressure, so just watch done
  always @(posedge clk) begin
    report_t got, want;
    if (!rst && done) begin
      got = '{report_channel, mean_q8, spread_q8, sample_count, insufficient,
              ped_out_of_range, spread_out_of_range, tube_off};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report ch=%0d", $time, report_channel);
      end else begin
        want = pending_reports.pop_front();
        if (got.ch !== want.ch || got.mean !== want.mean || got.spread !== want.spread ||
            got.cnt !== want.cnt || got.insuff !== want.insuff ||
            got.ped_oor !== want.ped_oor || got.spr_oor !== want.spr_oor ||
            got.off !== want.off) begin
          errors++;
          $display("%0t: mismatch exp ch=%0d mean=%0d spread=%0d n=%0d flags=%b%b%b%b",
                   $time, want.ch, want.mean, want.spread, want.cnt, want.insuff,
                   want.ped_oor, want.spr_oor, want.off);
          $display("%0t:          act ch=%0d mean=%0d spread=%0d n=%0d flags=%b%b%b%b",
                   $time, got.ch, got.mean, got.spread, got.cnt, got.insuff,
                   got.ped_oor, got.spr_oor, got.off);
        end
      end
    end
  end

  row_t directed[] = '{
    '{cps_pkg::FUNC_REPORT, 9'd0,   16'd0,    16'h0000, 1'b1,
      '{9'd0, 16'd0, 16'd0, 24'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{cps_pkg::FUNC_REPORT, 9'd511, 16'd0,    16'h0000, 1'b1,
      '{9'd511, 16'd0, 16'd0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{cps_pkg::FUNC_REPORT, 9'd489, 16'hFFFF, 16'hFFFF, 1'b1,
      '{9'd489, 16'd0, 16'd0, 24'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{cps_pkg::FUNC_REPORT, 9'd490, 16'd0,    16'h0001, 1'b1,
      '{9'd490, 16'd0, 16'd0, 24'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{cps_pkg::FUNC_SAMPLE, 9'd5,   16'd50,   16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd5,   -16'sd50, 16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_REPORT, 9'd5,   16'd0,    16'h0000, 1'b1,
      '{9'd5, 16'd12800, 16'd0, 24'd2, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{cps_pkg::FUNC_SAMPLE, 9'd3,   16'd0,    16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd3,   16'd100,  16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd3,   16'd99,   16'hFFFE, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd3,   16'h8000, 16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd3,   16'd99,   16'hFFFF, 1'b0, '0},
    '{cps_pkg::FUNC_REPORT, 9'd3,   16'd0,    16'h0000, 1'b1,
      '{9'd3, 16'd0, 16'd0, 24'd1, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{cps_pkg::FUNC_SAMPLE, 9'd3,   16'hFFFF, 16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd3,   16'h7FFF, 16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_REPORT, 9'd3,   16'd0,    16'h0000, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd511, 16'd7,    16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd511, -16'sd93, 16'h8001, 1'b0, '0},
    '{cps_pkg::FUNC_REPORT, 9'd511, 16'd0,    16'h0000, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd0,   16'd1,    16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_SAMPLE, 9'd0,   16'd2,    16'h0001, 1'b0, '0},
    '{cps_pkg::FUNC_REPORT, 9'd0,   16'd0,    16'h0000, 1'b0, '0}
  };

  // per-phase register values, indexed by register number
  logic [15:0] phase_regs [NPHASE][8] = '{
    '{16'd100,   16'd490, 16'd1792,  16'd512,   16'd2560,  16'd12800, 16'd512,   16'd1792},
    '{16'd32768, 16'd512, 16'd65535, 16'd0,     16'd0,     16'd65535, 16'd0,     16'd65535},
    '{16'd1,     16'd0,   16'd0,     16'd65535, 16'd65535, 16'd0,     16'd65535, 16'd0},
    '{16'd0,     16'd300, 16'd1000,  16'd200,   16'd1000,  16'd20000, 16'd100,   16'd3000},
    '{16'd5000,  16'd256, 16'd40000, 16'd3000,  16'd8000,  16'd60000, 16'd2000,  16'd50000}
  };

  logic [cps_pkg::CH_W-1:0] hot_channels [8] =
    '{9'd0, 9'd1, 9'd2, 9'd255, 9'd489, 9'd490, 9'd510, 9'd511};

  initial begin
    logic                     f;
    logic [cps_pkg::CH_W-1:0] ch;
    logic [15:0]              adc, code;
    int unsigned              mag;
    rst = 1'b1;
    start = 1'b0;
    func = 1'b0;
    channel = '0;
    adc_value = '0;
    event_code = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NCH; i++) begin
      ch_sum[i] = '0;
      ch_sqsum[i] = '0;
      ch_cnt[i] = '0;
    end
    lim_adc = 16'd100; lim_pmt = 10'd490; lim_off_up = 16'd1792; lim_off_lo = 16'd512;
    lim_ped_lo = 16'd2560; lim_ped_hi = 16'd12800; lim_spr_lo = 16'd512;
    lim_spr_hi = 16'd1792;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_item(directed[i].f, directed[i].ch, directed[i].adc, directed[i].code,
                directed[i].typed, directed[i].exp);

    for (int p = 0; p < NPHASE; p++) begin
      if (p > 0) begin
        drain();
        for (int r = 0; r < 8; r++) write_reg(cps_pkg::IDX_CW'(r), phase_regs[p][r]);
      end
      for (int k = 0; k < ITEMS_EACH; k++) begin
        f = ($urandom_range(0, 99) < 7) ? cps_pkg::FUNC_REPORT : cps_pkg::FUNC_SAMPLE;
        ch = ($urandom_range(0, 9) < 7) ? hot_channels[$urandom_range(0, 7)]
                                        : cps_pkg::CH_W'($urandom);
        code = 16'($urandom);
        adc = 16'($urandom);
        if (f == cps_pkg::FUNC_SAMPLE) begin
          if ($urandom_range(0, 99) < 85) code[0] = 1'b1;
          if ($urandom_range(0, 99) < 85 && lim_adc > 16'd1) begin
            mag = $urandom_range(1, 32'(lim_adc) - 1);
            adc = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
          end
        end
        send_item(f, ch, adc, code, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    $display("checked %0d reports over %0d samples in %0d register settings",
             reports_seen, samples_sent, NPHASE);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
